// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file lzss_chk.sv
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/lzss_pkg.sv
// shared types and constants of the lzss stream decompressor
// no dependencies; imported by every module of the block
package lzss_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int LB_W       = 3;
    localparam int LM_W       = 5;
    localparam int FLAGS_W    = 4;
    localparam int LEN_W      = 6;
    localparam int WORD_W     = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MASK = 1'b1;

    localparam logic [LB_W-1:0]    LENGTH_BITS_RESET = 3'd4;
    localparam logic [LM_W-1:0]    LENGTH_MASK_RESET = 5'd15;
    localparam logic [FLAGS_W-1:0] GROUP_SIZE        = 4'd8;
    localparam logic [LEN_W-1:0]   MIN_MATCH         = 6'd3;

    // parser position inside a flag group
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_BODY,
        PH_HIGH
    } phase_t;

    typedef enum logic [2:0] {
        ST_CLEAR_RST,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR_NS,
        ST_LIT,
        ST_COPY_RD,
        ST_COPY_WR
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic clear_step;
        logic load_flag;
        logic set_low;
        logic set_done;
        logic start_copy;
        logic rd;
        logic emit_lit;
        logic emit_copy;
        logic item_done;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic   ns_pending;
        logic   stream_done;
        phase_t phase;
        logic   flag_bit;
        logic   word_zero;
        logic   clear_last;
        logic   copy_last;
        logic   out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/lzss_in_if.sv
// compressed byte channel: valid, ready and payload
// depends on lzss_pkg for field widths
interface lzss_in_if
    import lzss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              new_stream;

    modport source (output valid, output in_byte, output new_stream, input ready);
    modport sink (input valid, input in_byte, input new_stream, output ready);
endinterface

// File: hw/rtl/lzss_out_if.sv
// decompressed byte channel: valid, ready and payload
// depends on lzss_pkg for field widths
interface lzss_out_if
    import lzss_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: hw/rtl/lzss_dpath.sv
// datapath: configuration, parser registers, history ring and output register
// depends on lzss_pkg; driven by lzss_ctrl through dp_cmd_t
module lzss_dpath
    import lzss_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  new_stream,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  out_last
);

    // largest power-of-two window that fits the storage
    localparam int PW        = $clog2(HISTORY_DEPTH + 1) - 1;
    localparam int MEM_DEPTH = 1 << PW;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [LB_W-1:0]    lb_reg, lb_next;
    logic [LM_W-1:0]    lm_reg, lm_next;
    logic [PW-1:0]      wpos_reg, wpos_next;
    logic [BYTE_W-1:0]  flag_bits_reg, flag_bits_next;
    logic [FLAGS_W-1:0] flags_left_reg, flags_left_next;
    phase_t             phase_reg, phase_next;
    logic               done_reg, done_next;
    logic               ns_reg, ns_next;
    logic [PW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [BYTE_W-1:0]  low_reg, low_next;
    logic [PW-1:0]      src_reg, src_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    logic [PW-1:0]      wmask;
    logic [PW-1:0]      wpos_init;
    logic [PW-1:0]      wpos_m;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  word_shift;
    logic [LEN_W-1:0]   match_len;
    logic [4:0]         win_log;
    logic [FLAGS_W-1:0] flags_dec;
    logic               mem_we;
    logic [PW-1:0]      mem_wa;
    logic [BYTE_W-1:0]  mem_wd;
    logic               emit;

    // window mask and stream start position from the current length field width
    always_comb
    begin
        win_log = 5'd16 - {2'b00, lb_reg};
        for (int i = 0; i < PW; i++)
        begin
            wmask[i]     = (5'(i) < win_log);
            wpos_init[i] = wmask[i] & !(5'(i) < {2'b00, lb_reg});
        end
    end

    assign wpos_m     = wpos_reg & wmask;
    assign word       = {byte_reg, low_reg};
    assign word_shift = word >> lb_reg;
    assign match_len  = LEN_W'(word[LM_W-1:0] & lm_reg) + MIN_MATCH;
    assign flags_dec  = flags_left_reg - 4'd1;
    assign emit       = cmd.emit_lit | cmd.emit_copy;

    // history write port: clearing sweep or emitted byte
    always_comb
    begin
        mem_we = cmd.clear_step | emit;
        if (cmd.clear_step)
        begin
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_wa = wpos_m;
            mem_wd = cmd.emit_lit ? byte_reg : rd_data_reg;
        end
    end

    // history ring, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[src_reg];
        end
    end

    // next-state logic of all registers
    always_comb
    begin
        lb_next         = lb_reg;
        lm_next         = lm_reg;
        wpos_next       = wpos_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        done_next       = done_reg;
        ns_next         = ns_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg;
        byte_next       = byte_reg;
        low_next        = low_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LENGTH_BITS: lb_next = cfg_data[LB_W-1:0];
                REG_LENGTH_MASK: lm_next = cfg_data[LM_W-1:0];
                default: ;
            endcase
        end

        // input transfer
        if (cmd.accept)
        begin
            byte_next = in_byte;
            ns_next   = new_stream;
        end

        // new stream restarts parser and write position
        if (cmd.start)
        begin
            ns_next         = 1'b0;
            wpos_next       = wpos_init;
            flag_bits_next  = '0;
            flags_left_next = '0;
            phase_next      = PH_FLAG;
            done_next       = 1'b0;
        end

        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.load_flag)
        begin
            flag_bits_next  = byte_reg;
            flags_left_next = GROUP_SIZE;
            phase_next      = PH_BODY;
        end

        if (cmd.set_low)
        begin
            low_next   = byte_reg;
            phase_next = PH_HIGH;
        end

        if (cmd.set_done)
        begin
            done_next = 1'b1;
        end

        // copy source and length from the reference word
        if (cmd.start_copy)
        begin
            src_next = (wpos_m - word_shift[PW-1:0]) & wmask;
            cnt_next = match_len;
        end

        // output register drains on its own transfer
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = mem_wd;
            out_last_next  = cmd.emit_lit | (cnt_reg == 6'd1);
            wpos_next      = (wpos_m + 1'b1) & wmask;
        end

        if (cmd.emit_copy)
        begin
            src_next = (src_reg + 1'b1) & wmask;
            cnt_next = cnt_reg - 6'd1;
        end

        if (cmd.item_done)
        begin
            flag_bits_next  = flag_bits_reg >> 1;
            flags_left_next = flags_dec;
            phase_next      = (flags_dec == '0) ? PH_FLAG : PH_BODY;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_reg         <= LENGTH_BITS_RESET;
            lm_reg         <= LENGTH_MASK_RESET;
            wpos_reg       <= PW'((MEM_DEPTH < 4096 ? MEM_DEPTH : 4096) - 16);
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            phase_reg      <= PH_FLAG;
            done_reg       <= 1'b0;
            ns_reg         <= 1'b0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lb_reg         <= lb_next;
            lm_reg         <= lm_next;
            wpos_reg       <= wpos_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            done_reg       <= done_next;
            ns_reg         <= ns_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        low_reg      <= low_next;
        src_reg      <= src_next;
        cnt_reg      <= cnt_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // status back to the controller
    always_comb
    begin
        status.ns_pending  = ns_reg;
        status.stream_done = done_reg;
        status.phase       = phase_reg;
        status.flag_bit    = flag_bits_reg[0];
        status.word_zero   = (word == '0);
        status.clear_last  = (clr_cnt_reg == '1);
        status.copy_last   = (cnt_reg == 6'd1);
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// File: hw/rtl/lzss_ctrl.sv
// controller: sequences clearing, parsing, literals and reference copies
// depends on lzss_pkg; commands lzss_dpath through dp_cmd_t
module lzss_ctrl
    import lzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR_RST:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (status.ns_pending)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CLEAR_NS;
                end
                else if (!status.stream_done)
                begin
                    case (status.phase)
                        PH_FLAG: cmd.load_flag = 1'b1;
                        PH_BODY:
                        begin
                            if (status.flag_bit)
                            begin
                                state_next = ST_LIT;
                            end
                            else
                            begin
                                cmd.set_low = 1'b1;
                            end
                        end
                        PH_HIGH:
                        begin
                            if (status.word_zero)
                            begin
                                cmd.set_done = 1'b1;
                            end
                            else
                            begin
                                cmd.start_copy = 1'b1;
                                state_next     = ST_COPY_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR_NS:
            begin
                // the byte that opened the stream is parsed once history is zero
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_LIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_lit  = 1'b1;
                    cmd.item_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_COPY_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_copy = 1'b1;
                    if (status.copy_last)
                    begin
                        cmd.item_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_COPY_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/lzss_stream_decompressor_core.sv
// top level of the lzss stream decompressor
// depends on lzss_pkg, lzss_in_if, lzss_out_if, lzss_ctrl and lzss_dpath
//
// channel        dir  handshake     payload
// compressed     in   valid/ready   in_byte[7:0], new_stream
// decompressed   out  valid/ready   out_byte[7:0], last_of_run
// cfg            in   cfg_we        cfg_index[0], cfg_data[4:0]
//
// flag, low-byte and ignored bytes are accepted and decoded, a literal then emits its byte
// a reference then copies length bytes: each copied byte is one read and one
// write of the history ring, in separate states
// after reset, and on each new_stream byte, a clearing pass zeroes all
// 2^floor(log2(HISTORY_DEPTH)) history entries (4096 by default) with no input taken
// the output register lets the next input be taken while a byte waits
module lzss_stream_decompressor_core
    import lzss_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lzss_in_if.sink               compressed,
    lzss_out_if.source            decompressed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .in_ready (compressed.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath and history ring
    lzss_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_byte    (compressed.in_byte),
        .new_stream (compressed.new_stream),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (decompressed.valid),
        .out_ready  (decompressed.ready),
        .out_byte   (decompressed.out_byte),
        .out_last   (decompressed.last_of_run)
    );

endmodule

// File: hw/rtl/lzss_chk.sv
// port-level checker for the lzss stream decompressor, bound to the top level
// depends on lzss_pkg and assert_macros.svh
`include "assert_macros.svh"

module lzss_chk
    import lzss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              out_last
);

    // stalled output holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "output valid dropped")
    `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last), "stalled output changed")

    // clearing pass blocks input right after reset
    `ASSERT_CLK_ALWAYS(a_clear_after_reset, clk, $rose(rst_n) |-> !in_ready, "input taken during clearing")

    // a byte that is not the last of its run means the copy is still busy
    `ASSERT_CLK(a_run_busy, clk, rst_n, out_valid && out_ready && !out_last |-> !in_ready, "input ready in mid run")

    // each transfer is decoded before the next is taken
    `ASSERT_CLK(a_decode_gap, clk, rst_n, in_valid && in_ready |=> !in_ready, "back to back input transfer")

endmodule

bind lzss_stream_decompressor_core lzss_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (compressed.valid),
    .in_ready  (compressed.ready),
    .out_valid (decompressed.valid),
    .out_ready (decompressed.ready),
    .out_byte  (decompressed.out_byte),
    .out_last  (decompressed.last_of_run)
);
